// ===== design/mhrsl_pkg.sv =====
package mhrsl_pkg;

   localparam int KEY_W      = 32;
   localparam int HASH_W     = 31;
   localparam int RCOUNT_W   = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;

   // Request commands.
   localparam logic [1:0] CMD_LOAD       = 2'd0;
   localparam logic [1:0] CMD_LOOKUP_INT = 2'd1;
   localparam logic [1:0] CMD_LOOKUP_STR = 2'd2;
   localparam logic [1:0] CMD_UNUSED     = 2'd3;

   // Response status codes.
   localparam logic [1:0] STAT_FOUND     = 2'd0;
   localparam logic [1:0] STAT_HASH_ERR  = 2'd1;
   localparam logic [1:0] STAT_NO_MATCH  = 2'd2;
   localparam logic [1:0] STAT_LOAD_DONE = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_MODULUS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_COUNT  = 1'b1;

   localparam logic [HASH_W-1:0]   MODULUS_RESET = 31'd256;
   localparam logic [RCOUNT_W-1:0] RCOUNT_RESET  = 9'd0;

   typedef struct packed {
      logic [1:0]         command;
      logic [7:0]         entry_index;
      logic signed [31:0] range_low;
      logic signed [31:0] range_high;
      logic signed [31:0] shard_value;
      logic [31:0]        search_key;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] shard_number;
      logic [HASH_W-1:0]  key_hash;
   } rsp_type;

   typedef struct packed {
      logic [31:0] low;
      logic [31:0] high;
      logic [31:0] shard;
   } entry_type;

   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] rem;
   } div_status_type;

   typedef struct packed {
      logic        done;
      logic        found;
      logic [31:0] shard;
   } srch_result_type;

endpackage

// ===== design/mhrsl_divider.sv =====
module mhrsl_divider
   import mhrsl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [KEY_W-1:0]  dividend,
   input  logic [HASH_W-1:0] divisor,
   output div_status_type    status
);

   // Restoring remainder, one dividend bit shifted in per cycle.
   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [HASH_W-1:0] div_ff, div_in;
   logic [HASH_W-1:0] rem_ff, rem_in;
   logic [HASH_W:0]   trial;
   logic [HASH_W:0]   diff;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      trial     = {rem_ff, key_ff[KEY_W-1]};
      diff      = trial - {1'b0, div_ff};
      if (start) begin
         active_in = 1'b1;
         cnt_in    = 5'd31;
         key_in    = dividend;
         div_in    = divisor;
         rem_in    = '0;
      end else if (active_ff) begin
         key_in = {key_ff[KEY_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[HASH_W-1:0];
         end else begin
            rem_in = trial[HASH_W-1:0];
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      key_ff <= key_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign status.done = done_ff;
   assign status.rem  = rem_ff;

endmodule

// ===== design/mhrsl_table.sv =====
module mhrsl_table
   import mhrsl_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
)
(
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mhrsl_search.sv =====
module mhrsl_search
   import mhrsl_pkg::*;
#(
   parameter int AW = 8,
   parameter int CW = 9
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [HASH_W-1:0] hash,
   input  logic [CW-1:0]     count,
   output logic [AW-1:0]     rd_addr,
   input  entry_type         rd_data,
   output srch_result_type   result
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADDR = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hx_ff, hx_in;
   logic [AW-1:0]     mid_ff, mid_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   srch_result_type   result_ff, result_in;
   logic [CW:0]       mid_sum;
   logic [AW-1:0]     mid;
   logic              go_low;
   logic              go_high;
   logic [CW-1:0]     lo_nx;
   logic [CW-1:0]     hx_nx;

   // The live window is [lo, hx); the probe is the floor midpoint of its inclusive bounds.
   assign mid_sum = (CW+1)'(lo_ff) + (CW+1)'(hx_ff) - (CW+1)'(1);
   assign mid     = AW'(mid_sum[CW:1]);
   assign rd_addr = mid;

   assign go_low  = $signed({2'b00, hash_ff}) < $signed({rd_data.low[31], rd_data.low});
   assign go_high = {1'b0, hash_ff} > rd_data.high;
   assign lo_nx   = go_low ? lo_ff : (CW'(mid_ff) + CW'(1));
   assign hx_nx   = go_low ? CW'(mid_ff) : hx_ff;

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hx_in     = hx_ff;
      mid_in    = mid_ff;
      hash_in   = hash_ff;
      result_in = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               lo_in   = '0;
               hx_in   = count;
               hash_in = hash;
               if (count == '0) begin
                  result_in.done = 1'b1;
               end else begin
                  state_in = S_ADDR;
               end
            end
         end
         S_ADDR: begin
            mid_in   = mid;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!go_low && !go_high) begin
               result_in.done  = 1'b1;
               result_in.found = 1'b1;
               result_in.shard = rd_data.shard;
               state_in        = S_IDLE;
            end else begin
               lo_in = lo_nx;
               hx_in = hx_nx;
               if (lo_nx >= hx_nx) begin
                  result_in.done = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_ADDR;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         result_ff <= '0;
      end else begin
         state_ff  <= state_in;
         result_ff <= result_in;
      end
      lo_ff   <= lo_in;
      hx_ff   <= hx_in;
      mid_ff  <= mid_in;
      hash_ff <= hash_in;
   end

   assign result = result_ff;

endmodule

// ===== design/modular_hash_range_shard_lookup_core.sv =====
// Channel    Direction  Ports                             Handshake
// request    in         start, busy, req_data             taken when start && !busy
// response   out        rsp_valid, rsp_data               one-cycle strobe, no backpressure
// csr        in         csr_write_en, csr_index, csr_wdata written when csr_write_en
//
// A load, an unused command or a lookup with a zero modulus raises rsp_valid on the edge
// that takes the request, and busy stays low. A lookup raises it after the bit-serial
// remainder, a step to start the search, the table probes (up to 9 at a depth of 256),
// each an address step and a compare step on the table port, and the response register.
// Reset is synchronous and resets the control and configuration registers; the table
// contents are undefined until loaded. The receiver cannot stall responses.
module modular_hash_range_shard_lookup_core
   import mhrsl_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Table address width and the width of a count that can hold the depth itself.
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // Top-level sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SRCH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [HASH_W-1:0]   modulus_ff;
   logic [RCOUNT_W-1:0] rcount_ff;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                div_start;
   logic                srch_start;
   logic [KEY_W-1:0]    dividend;
   logic [CW-1:0]       search_count;
   logic                tbl_wr_en;
   logic [AW-1:0]       tbl_wr_addr;
   entry_type           tbl_wr_data;
   logic [AW-1:0]       tbl_rd_addr;
   entry_type           tbl_rd_data;
   div_status_type      div_status;
   srch_result_type     srch_result;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // CSRs. User writes must arrive only while the block is idle; this is not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
         rcount_ff  <= RCOUNT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_HASH_MODULUS: modulus_ff <= csr_wdata;
            CSR_RANGE_COUNT:  rcount_ff  <= csr_wdata[RCOUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A load writes the table on the same edge that takes the request. A slot at or
   // beyond the table depth is dropped, but the load still reports completion.
   assign tbl_wr_en   = accept && (req_data.command == CMD_LOAD)
                        && (32'(req_data.entry_index) < 32'(TABLE_DEPTH));
   assign tbl_wr_addr = AW'(req_data.entry_index);
   assign tbl_wr_data = '{low:   req_data.range_low,
                          high:  req_data.range_high,
                          shard: req_data.shard_value};

   // A string key hashes only its first byte.
   assign dividend = (req_data.command == CMD_LOOKUP_STR) ?
                     {24'd0, req_data.search_key[7:0]} : req_data.search_key;

   // A count larger than the table searches the whole table.
   assign search_count = (32'(rcount_ff) > 32'(TABLE_DEPTH)) ?
                         CW'(TABLE_DEPTH) : CW'(rcount_ff);

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      srch_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.command)
                  CMD_LOAD: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{status: STAT_LOAD_DONE, shard_number: '0,
                                      key_hash: '0};
                  end
                  CMD_LOOKUP_INT, CMD_LOOKUP_STR: begin
                     if (modulus_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{status: STAT_HASH_ERR, shard_number: '0,
                                         key_hash: '0};
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  default: begin
                     // The unused command changes nothing and reports no match.
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{status: STAT_NO_MATCH, shard_number: '0,
                                      key_hash: '0};
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               hash_in    = div_status.rem;
               srch_start = 1'b1;
               state_in   = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (srch_result.done) begin
               rsp_valid_in = 1'b1;
               if (srch_result.found) begin
                  rsp_data_in = '{status: STAT_FOUND, shard_number: srch_result.shard,
                                  key_hash: hash_ff};
               end else begin
                  rsp_data_in = '{status: STAT_NO_MATCH, shard_number: '0,
                                  key_hash: hash_ff};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hash_ff     <= hash_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mhrsl_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (modulus_ff),
      .status   (div_status)
   );

   mhrsl_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   mhrsl_search #(
      .AW (AW),
      .CW (CW)
   ) u_search (
      .clock   (clock),
      .reset   (reset),
      .start   (srch_start),
      .hash    (div_status.rem),
      .count   (search_count),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data),
      .result  (srch_result)
   );

`ifndef SYNTHESIS
   // Every lookup that ends its search hands a response out on the same edge.
   assert property (@(posedge clock) disable iff (reset) $fell(busy) |-> rsp_valid)
      else $error("lookup finished without a response");

   // Only a match carries a shard number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STAT_FOUND) |-> (rsp_data.shard_number == '0))
      else $error("shard number set without a match");

   // The hash reported with a match is always a proper remainder of the modulus.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STAT_FOUND) |-> (rsp_data.key_hash < modulus_ff))
      else $error("key hash not below the modulus");

   // The remainder unit only reports while a lookup is waiting for it.
   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("remainder done outside a lookup");
`endif

endmodule

// ===== tb/shard_lookup_checker.sv =====
module shard_lookup_checker
   import mhrsl_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    answer_errors,
   output int                    answers_waiting
);

   entry_type            range_copy [TABLE_DEPTH];
   logic [HASH_W-1:0]    modulus_copy = MODULUS_RESET;
   logic [RCOUNT_W-1:0]  count_copy   = RCOUNT_RESET;
   rsp_type              awaited_answers [$];
   int                   error_total  = 0;

   // Works out the response that one request should produce from the
   // current table and register copies.
   function automatic rsp_type lookup_answer(input req_type r);
      rsp_type           ans;
      logic [31:0]       key;
      logic [HASH_W-1:0] hash;
      entry_type         e;
      int                lo;
      int                hi;
      int                mid;
      ans = '0;
      key = r.search_key;
      case (r.command)
         CMD_LOAD: begin
            ans.status = STAT_LOAD_DONE;
         end
         CMD_UNUSED: begin
            ans.status = STAT_NO_MATCH;
         end
         default: begin
            if (r.command == CMD_LOOKUP_STR) begin
               key = {24'd0, key[7:0]};
            end
            if (modulus_copy == '0) begin
               ans.status = STAT_HASH_ERR;
            end else begin
               hash = HASH_W'(key % {1'b0, modulus_copy});
               ans.status   = STAT_NO_MATCH;
               ans.key_hash = hash;
               lo = 0;
               hi = ((count_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_copy)) - 1;
               while (lo <= hi) begin
                  mid = (lo + hi) / 2;
                  e   = range_copy[mid];
                  // Low bound is signed, high bound unsigned.
                  if ($signed({2'b00, hash}) < $signed({e.low[31], e.low})) begin
                     hi = mid - 1;
                  end else if ({1'b0, hash} > e.high) begin
                     lo = mid + 1;
                  end else begin
                     ans.status       = STAT_FOUND;
                     ans.shard_number = e.shard;
                     lo               = hi + 1;
                  end
               end
            end
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         modulus_copy = MODULUS_RESET;
         count_copy   = RCOUNT_RESET;
         awaited_answers.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_HASH_MODULUS: modulus_copy = csr_wdata[HASH_W-1:0];
               CSR_RANGE_COUNT:  count_copy   = csr_wdata[RCOUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (awaited_answers.size() == 0) begin
               error_total++;
               if (error_total <= 10) begin
                  $display("response with no request waiting: status %0d shard %0d hash %0d",
                           rsp_data.status, rsp_data.shard_number, rsp_data.key_hash);
               end
            end else begin
               want = awaited_answers.pop_front();
               if (want.status !== rsp_data.status ||
                   want.shard_number !== rsp_data.shard_number ||
                   want.key_hash !== rsp_data.key_hash) begin
                  error_total++;
                  if (error_total <= 10) begin
                     $display("response mismatch: expected status %0d shard %0d hash %0d, %s",
                              want.status, want.shard_number, want.key_hash,
                              $sformatf("got status %0d shard %0d hash %0d",
                                        rsp_data.status, rsp_data.shard_number,
                                        rsp_data.key_hash));
                  end
               end
            end
         end
         if (start && !busy) begin
            awaited_answers.push_back(lookup_answer(req_data));
            if (req_data.command == CMD_LOAD && req_data.entry_index < TABLE_DEPTH) begin
               range_copy[req_data.entry_index] =
                  {req_data.range_low, req_data.range_high, req_data.shard_value};
            end
         end
      end
      answer_errors   <= error_total;
      answers_waiting <= awaited_answers.size();
   end

endmodule

// ===== tb/tb_modular_hash_range_shard_lookup_core.sv =====
// Top of the shard lookup testbench. It only produces stimulus and gives the
// verdict; the checker instance next to the block predicts every response and
// counts mismatches.
module tb_modular_hash_range_shard_lookup_core;
   import mhrsl_pkg::*;

   localparam int DEPTH       = 256;
   // Cycles with no request taken and no response seen before the run is
   // declared hung. The longest quiet stretch in a correct run is a lookup
   // overlapping a long sender gap, or the final drain.
   localparam int STALL_LIMIT = 1000;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  start        = 1'b0;
   req_type               req_data     = '0;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;
   logic                  busy;
   logic                  rsp_valid;
   rsp_type               rsp_data;

   int answer_errors;
   int answers_waiting;
   int quiet_cycles = 0;

   // Bounds of the ordered table that the random part loads. Reloads of a
   // slot put these values back, so the table stays mostly sorted.
   int plan_low  [DEPTH];
   int plan_high [DEPTH];
   int plan_top  = 0;

   // Burst shaping for the sender. In a steady phase the sender keeps start
   // high for long stretches with no gaps at all.
   int burst_left = 1;
   bit steady     = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   modular_hash_range_shard_lookup_core #(
      .TABLE_DEPTH (DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   shard_lookup_checker #(
      .TABLE_DEPTH (DEPTH)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .answer_errors   (answer_errors),
      .answers_waiting (answers_waiting)
   );

   // Watchdog: any request taken or response seen restarts the count.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("modular_hash_range_shard_lookup_core verification failed");
         $finish;
      end
   end

   // Every field gets random content so that fields the command ignores
   // still see all their bits move.
   function automatic req_type random_request(input logic [1:0] cmd);
      req_type r;
      r.command     = cmd;
      r.entry_index = 8'($urandom);
      r.range_low   = $urandom;
      r.range_high  = $urandom;
      r.shard_value = $urandom;
      r.search_key  = $urandom;
      return r;
   endfunction

   // Presents one request, waits for the edge that takes it, then sits out
   // any gap that ends the burst. Start is left high when the burst goes on,
   // so it is never lowered and raised in the same time step.
   task automatic send_request(input req_type r);
      int gap;
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = steady ? $urandom_range(16, 48) : $urandom_range(1, 8);
         if (steady) begin
            gap = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            // Long gaps land in the middle of a lookup's remainder and
            // probe phases.
            gap = $urandom_range(20, 70);
         end else begin
            gap = $urandom_range(0, 8);
         end
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic lookup_key(input logic [1:0] cmd, input logic [31:0] key);
      req_type r;
      r            = random_request(cmd);
      r.search_key = key;
      send_request(r);
   endtask

   task automatic load_entry(input int idx, input logic [31:0] low, input logic [31:0] high,
                             input logic [31:0] shard);
      req_type r;
      r             = random_request(CMD_LOAD);
      r.entry_index = idx[7:0];
      r.range_low   = low;
      r.range_high  = high;
      r.shard_value = shard;
      send_request(r);
   endtask

   // Holds requests back until every predicted response has arrived. Every
   // request produces a response, so the block is idle at that point. The
   // first edge lets the checker's count catch up with the last request.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (answers_waiting != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      settle();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // The range count register is nine bits wide; the upper write data bits
   // get random values that the block should drop.
   task automatic write_count(input int count);
      logic [31:0] upper;
      upper = $urandom;
      write_reg(CSR_RANGE_COUNT, {upper[21:0], 9'(count)});
   endtask

   // Loads every slot with ascending, disjoint ranges separated by
   // random holes, so lookups hit, fall between ranges, or run off the end.
   task automatic build_ordered_table();
      int cursor;
      cursor = 0;
      for (int i = 0; i < DEPTH; i++) begin
         plan_low[i]  = cursor + $urandom_range(0, 12);
         plan_high[i] = plan_low[i] + $urandom_range(0, 63);
         cursor       = plan_high[i] + 1;
         load_entry(i, plan_low[i], plan_high[i], $urandom);
      end
      plan_top = cursor;
   endtask

   // Mostly lookups against the ordered table, with reloads that keep the
   // order, unused commands, and some loads of random values into random
   // slots that break the order for a while.
   task automatic mixed_traffic(input int n);
      int pick;
      int idx;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 1) == 1) begin
               lookup_key(CMD_LOOKUP_INT, $urandom_range(0, plan_top + plan_top / 8));
            end else begin
               lookup_key(CMD_LOOKUP_INT, $urandom);
            end
         end else if (pick < 65) begin
            lookup_key(CMD_LOOKUP_STR, $urandom);
         end else if (pick < 70) begin
            send_request(random_request(CMD_UNUSED));
         end else if (pick < 90) begin
            idx = $urandom_range(0, DEPTH - 1);
            load_entry(idx, plan_low[idx], plan_high[idx], $urandom);
         end else begin
            send_request(random_request(CMD_LOAD));
         end
      end
   endtask

   initial begin
      int          count_val;
      logic [30:0] modulus_val;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table: range count is zero after reset, so every lookup misses
      // but still reports the hash under the reset modulus of 256.
      lookup_key(CMD_LOOKUP_INT, 32'h0000_0000);
      lookup_key(CMD_LOOKUP_INT, 32'hFFFF_FFFF);
      // A string lookup keeps only the first byte of the key.
      lookup_key(CMD_LOOKUP_STR, 32'hFFFF_FF80);
      // The unused command answers with a miss and zero fields.
      send_request(random_request(CMD_UNUSED));

      // A small table with extreme bounds: the most negative low bound, a
      // high bound that is huge when read unsigned, and a last range that
      // no hash can reach, so the search always turns lower there.
      load_entry(0, 32'h8000_0000, 32'h0000_000F, 32'h7FFF_FFFF);
      load_entry(1, 32'd16, 32'd99, 32'h8000_0000);
      load_entry(2, 32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      load_entry(3, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      write_count(4);
      lookup_key(CMD_LOOKUP_INT, 32'd5);
      lookup_key(CMD_LOOKUP_INT, 32'd50);
      lookup_key(CMD_LOOKUP_INT, 32'd200);
      lookup_key(CMD_LOOKUP_STR, 32'h0000_00FF);

      // A zero modulus is flagged instead of dividing.
      write_reg(CSR_HASH_MODULUS, '0);
      lookup_key(CMD_LOOKUP_INT, $urandom);
      lookup_key(CMD_LOOKUP_STR, $urandom);

      // Smallest and largest moduli.
      write_reg(CSR_HASH_MODULUS, 31'd1);
      lookup_key(CMD_LOOKUP_INT, 32'hFFFF_FFFF);
      write_reg(CSR_HASH_MODULUS, 31'h7FFF_FFFF);
      lookup_key(CMD_LOOKUP_INT, 32'hFFFF_FFFF);
      lookup_key(CMD_LOOKUP_INT, 32'h7FFF_FFFE);
      lookup_key(CMD_LOOKUP_INT, 32'h7FFF_FFFF);

      // Fill every slot so that any range count, including counts above the
      // table depth, only ever reads written entries.
      build_ordered_table();

      // Register settings per phase, with the extremes of both registers.
      // Each phase starts with the sender holding off until all responses
      // are in, since registers are only written while the block is idle.
      for (int p = 0; p < 8; p++) begin
         steady = (p % 3 == 2);
         case (p)
            0: begin
               modulus_val = 31'(plan_top + $urandom_range(0, 200));
               count_val   = DEPTH;
            end
            1: begin
               modulus_val = 31'($urandom_range(1, plan_top));
               count_val   = $urandom_range(1, DEPTH - 1);
            end
            2: begin
               // A count beyond the depth searches the whole table.
               modulus_val = 31'h7FFF_FFFF;
               count_val   = 511;
            end
            3: begin
               modulus_val = 31'($urandom_range(1, 1000));
               count_val   = DEPTH + 1;
            end
            4: begin
               modulus_val = 31'd1;
               count_val   = 1;
            end
            5: begin
               modulus_val = MODULUS_RESET;
               count_val   = 0;
            end
            6: begin
               modulus_val = '0;
               count_val   = $urandom_range(1, DEPTH);
            end
            default: begin
               modulus_val = 31'($urandom_range(plan_top / 2, plan_top * 2));
               count_val   = DEPTH / 2;
            end
         endcase
         write_reg(CSR_HASH_MODULUS, modulus_val);
         write_count(count_val);
         mixed_traffic(25);
      end

      // Drain, then allow a lookup's worth of cycles for any stray response.
      settle();
      repeat (60) @(posedge clock);
      if (answer_errors == 0 && answers_waiting == 0) begin
         $display("modular_hash_range_shard_lookup_core verification clean");
      end else begin
         $display("modular_hash_range_shard_lookup_core verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/mhrsl_pkg.sv
design/mhrsl_divider.sv
design/mhrsl_table.sv
design/mhrsl_search.sv
design/modular_hash_range_shard_lookup_core.sv
tb/shard_lookup_checker.sv
tb/tb_modular_hash_range_shard_lookup_core.sv
